FILE: design/cap_pkg.sv
// shared types and constants of the cascaded attitude pid block
package cap_pkg;

    // number of pid loops and their order in the state arrays
    localparam int NUM_PID = 5;
    localparam logic [2:0] PID_RA = 3'd0;
    localparam logic [2:0] PID_PA = 3'd1;
    localparam logic [2:0] PID_RR = 3'd2;
    localparam logic [2:0] PID_PR = 3'd3;
    localparam logic [2:0] PID_YR = 3'd4;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_RA_GAINS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PA_GAINS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RR_GAINS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PR_GAINS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_YR_GAINS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMITS   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 3'd6;

    // field widths
    localparam int FIELD_W  = 32;
    localparam int NUM_IN   = 8;
    localparam int NUM_OUT  = 3;
    localparam int GAIN_W   = 16;
    localparam int GAINS_W  = 48;
    localparam int LIMITS_W = 64;
    localparam int PERIOD_W = 16;
    localparam int ACC_W    = 40;
    localparam int CFG_W    = 64;

    // reset values of the configuration registers
    localparam logic [LIMITS_W-1:0] LIMITS_RST = 64'h00C8_0064_01F4_00C8;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd655;

    // derivative divider: dividend is |diff| << 16 with a 33-bit diff
    localparam int DQW        = 49;
    localparam int DIV_STEPS  = DQW;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // per-loop sequence phases
    localparam logic [2:0] PH_ERR = 3'd0;
    localparam logic [2:0] PH_DT  = 3'd1;
    localparam logic [2:0] PH_ACC = 3'd2;
    localparam logic [2:0] PH_P   = 3'd3;
    localparam logic [2:0] PH_I   = 3'd4;
    localparam logic [2:0] PH_D   = 3'd5;
    localparam logic [2:0] PH_OUT = 3'd6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       load;
        logic       div_step;
        logic       finish;
        logic       run;
        logic [2:0] pid_idx;
        logic [2:0] phase;
        logic       out_load;
    } cap_cmd_t;

endpackage

FILE: design/cap_ctrl.sv
// sequencer of the cascaded attitude pid block
module cap_ctrl import cap_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output cap_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_FIN  = 6'b001000,
        ST_RUN  = 6'b010000,
        ST_DONE = 6'b100000
    } cap_state_t;

    cap_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [2:0]           pid_reg, pid_next;
    logic [2:0]           phase_reg, phase_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        pid_next     = pid_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.pid_idx  = pid_reg;
        cmd.phase    = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load     = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                pid_next   = PID_RA;
                phase_next = PH_ERR;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.run = 1'b1;
                if (phase_reg == PH_OUT) begin
                    phase_next = PH_ERR;
                    if (pid_reg == PID_YR) begin
                        state_next = ST_DONE;
                    end else begin
                        pid_next = pid_reg + 3'd1;
                    end
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            div_cnt_reg  <= '0;
            pid_reg      <= PID_RA;
            phase_reg    <= PH_ERR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_cnt_reg  <= div_cnt_next;
            pid_reg      <= pid_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: design/cap_datapath.sv
// arithmetic, loop state and configuration registers of the attitude pid
module cap_datapath import cap_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [REG_IDX_W-1:0]        cfg_addr,
    input  logic [CFG_W-1:0]            cfg_wdata,
    input  logic [NUM_IN*FIELD_W-1:0]   s_tdata,
    input  cap_cmd_t                    cmd,
    output logic [NUM_OUT*FIELD_W-1:0]  m_tdata
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = (SW + 1 > ACC_W) ? SW + 1 : ACC_W;
    localparam int PW   = AW + GAIN_W + 1;
    localparam int SUMW = PW - 6;
    localparam int IW   = PW - 15;
    localparam int EW   = AW + 1;
    localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SMIN = ~SMAX;
    localparam logic signed [SUMW-1:0] FMAX =
        {{(SUMW-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
    localparam logic signed [SUMW-1:0] FMIN = ~FMAX;

    // configuration
    logic [GAINS_W-1:0]  gains_reg [NUM_PID];
    logic [LIMITS_W-1:0] limits_reg;
    logic [PERIOD_W-1:0] period_reg;

    // captured request and loop state
    logic signed [FIELD_W-1:0] in_reg   [NUM_IN];
    logic signed [ACC_W-1:0]   acc_reg  [NUM_PID];
    logic signed [FIELD_W-1:0] last_reg [NUM_PID];

    // divider lanes
    logic [PERIOD_W-1:0] dt_reg;
    logic [PERIOD_W-1:0] rem_reg [NUM_PID];
    logic [DQW-1:0]      quo_reg [NUM_PID];
    logic                neg_reg [NUM_PID];
    logic signed [SW-1:0] deriv_reg [NUM_PID];

    // shared evaluation registers
    logic signed [SW-1:0]      e_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [ACC_W-1:0]   accn_reg;
    logic signed [SUMW-1:0]    sum_reg;
    logic signed [SW-1:0]      res_reg [NUM_PID];
    logic [FIELD_W-1:0]        out_reg [NUM_OUT];

    // per-loop selections
    logic [GAINS_W-1:0]      gsel;
    logic [GAIN_W-1:0]       kp, ki, kd;
    logic [GAIN_W-1:0]       omax, imax;
    logic signed [EW-1:0]    err;
    logic signed [AW-1:0]    mul_a;
    logic signed [GAIN_W:0]  mul_b;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    rnd16, rnd8;
    logic signed [IW-1:0]    acc_sum, ilim;
    logic signed [ACC_W-1:0] acc_clamped;
    logic signed [SUMW-1:0]  olim, out_clamped;

    // saturate to the sample width
    function automatic logic signed [SW-1:0] sat_sw(input logic signed [SUMW-1:0] x);
        logic signed [SUMW-1:0] y;
        if (x > SMAX) begin
            y = SMAX;
        end else if (x < SMIN) begin
            y = SMIN;
        end else begin
            y = x;
        end
        return y[SW-1:0];
    endfunction

    // saturate to the 32-bit output field
    function automatic logic [FIELD_W-1:0] sat_field(input logic signed [SUMW-1:0] x);
        logic signed [SUMW-1:0] y;
        if (x > FMAX) begin
            y = FMAX;
        end else if (x < FMIN) begin
            y = FMIN;
        end else begin
            y = x;
        end
        return y[FIELD_W-1:0];
    endfunction

    // gain and limit fields of the current loop
    always_comb begin
        gsel = gains_reg[cmd.pid_idx];
        kp   = gsel[47:32];
        ki   = gsel[31:16];
        kd   = gsel[15:0];
        if (cmd.pid_idx == PID_RA || cmd.pid_idx == PID_PA) begin
            omax = limits_reg[63:48];
            imax = limits_reg[47:32];
        end else begin
            omax = limits_reg[31:16];
            imax = limits_reg[15:0];
        end
    end

    // loop error: outer loops on angle, inner roll/pitch on outer result, yaw on rate
    always_comb begin
        case (cmd.pid_idx)
            PID_RA:  err = EW'(in_reg[0]) - EW'(in_reg[3]);
            PID_PA:  err = EW'(in_reg[1]) - EW'(in_reg[4]);
            PID_RR:  err = EW'(res_reg[PID_RA]) - EW'(in_reg[5]);
            PID_PR:  err = EW'(res_reg[PID_PA]) - EW'(in_reg[6]);
            PID_YR:  err = EW'(in_reg[2]) - EW'(in_reg[7]);
            default: err = '0;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        case (cmd.phase)
            PH_DT: begin
                mul_a = AW'(e_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            PH_ACC: begin
                mul_a = AW'(e_reg);
                mul_b = $signed({1'b0, kp});
            end
            PH_P: begin
                mul_a = AW'(accn_reg);
                mul_b = $signed({1'b0, ki});
            end
            PH_I: begin
                mul_a = -AW'(deriv_reg[cmd.pid_idx]);
                mul_b = $signed({1'b0, kd});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    // rounding, integral clamp and output clamp
    always_comb begin
        rnd16   = (prod_reg + PW'(32768)) >>> 16;
        rnd8    = (prod_reg + PW'(128)) >>> 8;
        acc_sum = IW'(acc_reg[cmd.pid_idx]) + IW'(rnd16);
        ilim    = IW'({imax, 16'b0});
        if (acc_sum > ilim) begin
            acc_clamped = ACC_W'(ilim);
        end else if (acc_sum < -ilim) begin
            acc_clamped = ACC_W'(-ilim);
        end else begin
            acc_clamped = ACC_W'(acc_sum);
        end
        olim = SUMW'({omax, 16'b0});
        if (sum_reg > olim) begin
            out_clamped = olim;
        end else if (sum_reg < -olim) begin
            out_clamped = -olim;
        end else begin
            out_clamped = sum_reg;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PID; i++) begin
                gains_reg[i] <= '0;
            end
            limits_reg <= LIMITS_RST;
            period_reg <= PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RA_GAINS, REG_PA_GAINS, REG_RR_GAINS, REG_PR_GAINS,
                REG_YR_GAINS: gains_reg[cfg_addr] <= cfg_wdata[GAINS_W-1:0];
                REG_LIMITS:   limits_reg <= cfg_wdata[LIMITS_W-1:0];
                REG_PERIOD:   period_reg <= cfg_wdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // integral and last measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PID; i++) begin
                acc_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                for (int i = 0; i < NUM_PID; i++) begin
                    last_reg[i] <= in_reg[i+3];
                end
            end
            if (cmd.run && cmd.phase == PH_ACC) begin
                acc_reg[cmd.pid_idx] <= acc_clamped;
            end
        end
    end

    // request capture, divider lanes and evaluation
    always_ff @(posedge aclk) begin
        logic signed [32:0]     diff;
        logic [32:0]            mag;
        logic [PERIOD_W:0]      trial;
        logic signed [SUMW-1:0] q;
        if (cmd.capture) begin
            for (int i = 0; i < NUM_IN; i++) begin
                in_reg[i] <= s_tdata[i*FIELD_W +: FIELD_W];
            end
        end
        if (cmd.load) begin
            dt_reg <= (period_reg == '0) ? PERIOD_W'(1) : period_reg;
            for (int i = 0; i < NUM_PID; i++) begin
                diff = 33'(in_reg[i+3]) - 33'(last_reg[i]);
                mag  = diff[32] ? 33'(-diff) : 33'(diff);
                neg_reg[i] <= diff[32];
                rem_reg[i] <= '0;
                quo_reg[i] <= {mag, 16'b0};
            end
        end
        // one restoring step per lane
        if (cmd.div_step) begin
            for (int i = 0; i < NUM_PID; i++) begin
                trial = {rem_reg[i], quo_reg[i][DQW-1]};
                if (trial >= {1'b0, dt_reg}) begin
                    rem_reg[i] <= PERIOD_W'(trial - {1'b0, dt_reg});
                    quo_reg[i] <= {quo_reg[i][DQW-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial[PERIOD_W-1:0];
                    quo_reg[i] <= {quo_reg[i][DQW-2:0], 1'b0};
                end
            end
        end
        // signed, saturated derivative
        if (cmd.finish) begin
            for (int i = 0; i < NUM_PID; i++) begin
                q = $signed(SUMW'(quo_reg[i]));
                deriv_reg[i] <= sat_sw(neg_reg[i] ? -q : q);
            end
        end
        if (cmd.run) begin
            case (cmd.phase)
                PH_ERR: e_reg <= sat_sw(SUMW'(err));
                PH_DT:  prod_reg <= prod_next;
                PH_ACC: begin
                    accn_reg <= acc_clamped;
                    prod_reg <= prod_next;
                end
                PH_P: begin
                    sum_reg  <= SUMW'(rnd8);
                    prod_reg <= prod_next;
                end
                PH_I: begin
                    sum_reg  <= sum_reg + SUMW'(rnd8);
                    prod_reg <= prod_next;
                end
                PH_D:   sum_reg <= sum_reg + SUMW'(rnd8);
                PH_OUT: res_reg[cmd.pid_idx] <= sat_sw(out_clamped);
                default: begin
                end
            endcase
        end
        if (cmd.out_load) begin
            for (int j = 0; j < NUM_OUT; j++) begin
                out_reg[j] <= sat_field(SUMW'(res_reg[j+2]));
            end
        end
    end

    assign m_tdata = {out_reg[2], out_reg[1], out_reg[0]};

endmodule

FILE: design/cascaded_attitude_pid.sv
// top level of the cascaded attitude pid controller
//
// One request carries roll/pitch angle targets, a yaw rate target, the two
// measured angles and three gyro rates; one result carries roll, pitch and
// yaw drive values, all signed Q16.16. A request is captured, the divider
// is loaded, the bit-serial derivative division runs (five lanes, one per
// loop, side by side), the quotients are saturated, then the five loops run
// in cascade order on one shared multiplier, and the result is posted. The
// result sits in an output register, so the next request is taken while it
// waits; a result is posted only once that register is free. Write
// configuration registers only while the block is idle.
module cascaded_attitude_pid import cap_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [REG_IDX_W-1:0]        cfg_addr,
    input  logic [CFG_W-1:0]            cfg_wdata,
    // input request
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // roll_setpoint, pitch_setpoint, yaw_rate_setpoint, roll_angle,
    // pitch_angle, roll_gyro, pitch_gyro, yaw_gyro (32 bits each, lowest first)
    input  logic [NUM_IN*FIELD_W-1:0]   s_tdata,
    // output result
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // roll_drive, pitch_drive, yaw_drive (32 bits each, lowest first)
    output logic [NUM_OUT*FIELD_W-1:0]  m_tdata
);

    cap_cmd_t cmd;

    cap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cap_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // an accepted request closes the input until it is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after accept");

    // a new result is only posted into a free output slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending output");

    // a posted result shows up as valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("posted result not valid");
`endif

endmodule

FILE: tb/cascaded_attitude_pid_test.sv
// self-checking bench for the cascaded attitude pid controller
module cascaded_attitude_pid_test;
    import cap_pkg::*;

    // one input request, first field in the lowest bits
    typedef struct packed {
        logic signed [31:0] yaw_gyro;
        logic signed [31:0] pitch_gyro;
        logic signed [31:0] roll_gyro;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] yaw_rate_setpoint;
        logic signed [31:0] pitch_setpoint;
        logic signed [31:0] roll_setpoint;
    } attitude_req_t;

    // one result, roll drive in the lowest bits
    typedef struct packed {
        logic signed [31:0] yaw_drive;
        logic signed [31:0] pitch_drive;
        logic signed [31:0] roll_drive;
    } drive_set_t;

    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr = REG_RA_GAINS;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [NUM_IN*FIELD_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [NUM_OUT*FIELD_W-1:0] m_tdata;

    cascaded_attitude_pid dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow of the configuration and the loop state
    logic [GAINS_W-1:0] loop_gains [NUM_PID];
    logic [LIMITS_W-1:0] loop_limits = LIMITS_RST;
    logic [PERIOD_W-1:0] loop_period = PERIOD_RST;
    longint integ_acc [NUM_PID];
    longint last_meas [NUM_PID];

    attitude_req_t pending_reqs[$];
    drive_set_t expected_drives[$];
    bit calm = 1'b0;
    bit req_taken = 1'b0;
    int unsigned errors = 0;
    int unsigned reqs_sent = 0;
    int unsigned drives_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp_lim(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // add half then floor
    function automatic longint round_shift(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // one pid loop with derivative on measurement
    function automatic longint pid_loop(int k, longint err, longint meas,
                                        longint omax, longint imax, longint dt);
        longint kp, ki, kd, e, acc, diff, deriv, sum;
        longint big;
        kp = longint'(loop_gains[k][47:32]);
        ki = longint'(loop_gains[k][31:16]);
        kd = longint'(loop_gains[k][15:0]);
        big = 64'sd1 <<< 47;
        e = sat32(err);
        acc = clamp_lim(integ_acc[k] + round_shift(e * dt, 16), imax * 65536);
        integ_acc[k] = acc;
        diff = meas - last_meas[k];
        if (diff >= big) deriv = sat32(big);
        else if (diff <= -big) deriv = sat32(-big);
        else deriv = sat32((diff * 65536) / dt);
        last_meas[k] = meas;
        sum = round_shift(kp * e, 8) + round_shift(ki * acc, 8)
            + round_shift(kd * (-deriv), 8);
        return sat32(clamp_lim(sum, omax * 65536));
    endfunction

    // cascade: angle loops feed the roll and pitch rate loops
    function automatic drive_set_t attitude_step(attitude_req_t r);
        longint a_omax, a_imax, r_omax, r_imax, dt, rate_roll, rate_pitch;
        drive_set_t d;
        a_omax = longint'(loop_limits[63:48]);
        a_imax = longint'(loop_limits[47:32]);
        r_omax = longint'(loop_limits[31:16]);
        r_imax = longint'(loop_limits[15:0]);
        dt = (loop_period == 0) ? 1 : longint'(loop_period);
        rate_roll = pid_loop(PID_RA, longint'(r.roll_setpoint) - longint'(r.roll_angle),
                             longint'(r.roll_angle), a_omax, a_imax, dt);
        rate_pitch = pid_loop(PID_PA, longint'(r.pitch_setpoint) - longint'(r.pitch_angle),
                              longint'(r.pitch_angle), a_omax, a_imax, dt);
        d.roll_drive = 32'(pid_loop(PID_RR, rate_roll - longint'(r.roll_gyro),
                                    longint'(r.roll_gyro), r_omax, r_imax, dt));
        d.pitch_drive = 32'(pid_loop(PID_PR, rate_pitch - longint'(r.pitch_gyro),
                                     longint'(r.pitch_gyro), r_omax, r_imax, dt));
        d.yaw_drive = 32'(pid_loop(PID_YR,
                                   longint'(r.yaw_rate_setpoint) - longint'(r.yaw_gyro),
                                   longint'(r.yaw_gyro), r_omax, r_imax, dt));
        return d;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h (result %0d)", what, want, got,
                 drives_seen);
        errors++;
    endtask

    // request driver
    always @(negedge aclk) begin
        if (s_tvalid && !req_taken) begin
            s_tvalid <= 1'b1;
        end else if (in_gap > 0) begin
            in_gap--;
            s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            s_tdata <= pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            in_gap = pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result stall pattern
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            out_gap = pick_gap();
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        drive_set_t got, want;
        if (aresetn) begin
            req_taken = s_tvalid && s_tready;
            if (req_taken) begin
                expected_drives.push_back(attitude_step(attitude_req_t'(s_tdata)));
                reqs_sent++;
            end
            if (m_tvalid && m_tready) begin
                got = drive_set_t'(m_tdata);
                drives_seen++;
                if (expected_drives.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_tdata[31:0]);
                end else begin
                    want = expected_drives.pop_front();
                    if (got.roll_drive !== want.roll_drive)
                        report_mismatch("roll_drive", want.roll_drive, got.roll_drive);
                    if (got.pitch_drive !== want.pitch_drive)
                        report_mismatch("pitch_drive", want.pitch_drive, got.pitch_drive);
                    if (got.yaw_drive !== want.yaw_drive)
                        report_mismatch("yaw_drive", want.yaw_drive, got.yaw_drive);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_drives.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // register write, shadowed in the predictor
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        cfg_writes++;
        if (idx < REG_LIMITS) loop_gains[idx] = val[GAINS_W-1:0];
        else if (idx == REG_LIMITS) loop_limits = val;
        else if (idx == REG_PERIOD) loop_period = val[PERIOD_W-1:0];
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_drives.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_limit();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 600));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [GAINS_W-1:0] rand_gains();
        case ($urandom_range(0, 3))
            0: return {16'($urandom_range(0, 511)), 16'($urandom_range(0, 511)),
                       16'($urandom_range(0, 511))};
            1: return {16'($urandom), 32'($urandom)};
            2: return {GAINS_W{1'b1}};
            default: return {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 64)),
                             16'($urandom_range(0, 32))};
        endcase
    endfunction

    function automatic logic [15:0] rand_period();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return PERIOD_RST;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        if (r < 85) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic attitude_req_t rand_req();
        attitude_req_t r;
        r.roll_setpoint = rand_field();
        r.pitch_setpoint = rand_field();
        r.yaw_rate_setpoint = rand_field();
        r.roll_angle = rand_field();
        r.pitch_angle = rand_field();
        r.roll_gyro = rand_field();
        r.pitch_gyro = rand_field();
        r.yaw_gyro = rand_field();
        return r;
    endfunction

    function automatic attitude_req_t same_req(logic [31:0] t, logic [31:0] m);
        return {m, m, m, m, m, t, t, t};
    endfunction

    // stimulus phases
    initial begin
        for (int k = 0; k < NUM_PID; k++) begin
            loop_gains[k] = '0;
            integ_acc[k] = 0;
            last_meas[k] = 0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration: zero gains
        for (int i = 0; i < 3; i++) pending_reqs.push_back(rand_req());
        drain();

        // directed: wide limits, moderate gains
        for (int k = 0; k < NUM_PID; k++) write_reg(REG_IDX_W'(k), 64'h0180_0040_0020);
        write_reg(REG_LIMITS, {LIMITS_W{1'b1}});
        write_reg(REG_PERIOD, 64'd655);
        write_reg(3'd7, {CFG_W{1'b1}});
        end_writes();
        pending_reqs.push_back(same_req(32'h0, 32'h0));
        pending_reqs.push_back(same_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_reqs.push_back(same_req(32'h8000_0000, 32'h8000_0000));
        // error overflow both ways, measurement jump across full range
        pending_reqs.push_back(same_req(32'h7FFF_FFFF, 32'h8000_0000));
        pending_reqs.push_back(same_req(32'h8000_0000, 32'h7FFF_FFFF));
        pending_reqs.push_back(same_req(32'h0001_0000, 32'hFFFF_0000));
        pending_reqs.push_back(same_req(32'h5555_5555, 32'hAAAA_AAAA));
        pending_reqs.push_back(same_req(32'hAAAA_AAAA, 32'h5555_5555));
        drain();

        // zero period and zero limits
        write_reg(REG_PERIOD, 64'd0);
        write_reg(REG_LIMITS, 64'd0);
        end_writes();
        pending_reqs.push_back(same_req(32'h0003_0000, 32'h0001_0000));
        pending_reqs.push_back(same_req(32'h7FFF_FFFF, 32'h8000_0000));
        pending_reqs.push_back(same_req(32'hFFFF_FFFF, 32'h0000_0001));
        drain();

        // full gains, longest period
        for (int k = 0; k < NUM_PID; k++) write_reg(REG_IDX_W'(k), {GAINS_W{1'b1}});
        write_reg(REG_LIMITS, {LIMITS_W{1'b1}});
        write_reg(REG_PERIOD, 64'hFFFF);
        end_writes();
        pending_reqs.push_back(same_req(32'h7FFF_FFFF, 32'h8000_0000));
        pending_reqs.push_back(same_req(32'h8000_0000, 32'h7FFF_FFFF));
        pending_reqs.push_back(same_req(32'h0000_0100, 32'h0000_0080));
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph % 4 == 3);
            for (int k = 0; k < NUM_PID; k++) write_reg(REG_IDX_W'(k), rand_gains());
            write_reg(REG_LIMITS, {rand_limit(), rand_limit(), rand_limit(), rand_limit()});
            write_reg(REG_PERIOD, 64'(rand_period()));
            write_reg(3'd7, {$urandom, $urandom});
            end_writes();
            for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());
            drain();
        end

        $display("covered %0d requests and %0d results over %0d register writes",
                 reqs_sent, drives_seen, cfg_writes);
        $display("settings included zero/max gains, limits and loop periods");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
